// File: hw/rtl/tkx_pkg.sv
// tkx_pkg: types, constants and generator step functions for the keystream xor block
// no dependencies; used by tkx_keystream and tausworthe_keystream_xor
`default_nettype none

package tkx_pkg;

   localparam logic [31:0] MASK_A = 32'hFFFF_FFFE;
   localparam logic [31:0] MASK_B = 32'hFFFF_FFF8;
   localparam logic [31:0] MASK_C = 32'hFFFF_FFF0;

   localparam logic [31:0] SEED_OR_A = 32'h0000_0003;
   localparam logic [31:0] SEED_OR_B = 32'h0000_0009;
   localparam logic [31:0] SEED_OR_C = 32'h0000_0017;

   localparam int WARMUP_STEPS = 6;

   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   localparam logic [1:0] REG_SEED_A = 2'd0;
   localparam logic [1:0] REG_SEED_B = 2'd1;
   localparam logic [1:0] REG_SEED_C = 2'd2;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } tkx_words_type;

   typedef struct packed {
      logic load;
      logic advance;
   } tkx_gen_ctl_type;

   function automatic tkx_words_type tkx_advance(input tkx_words_type w);
      tkx_words_type r;
      r.a = ((w.a & MASK_A) << 12) ^ (((w.a << 13) ^ w.a) >> 19);
      r.b = ((w.b & MASK_B) << 4)  ^ (((w.b << 2)  ^ w.b) >> 25);
      r.c = ((w.c & MASK_C) << 17) ^ (((w.c << 3)  ^ w.c) >> 11);
      return r;
   endfunction

   function automatic tkx_words_type tkx_warmup(input tkx_words_type w);
      tkx_words_type r;
      r = w;
      for (int k = 0; k < WARMUP_STEPS; k++) begin
         r = tkx_advance(r);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tkx_keystream.sv
// tkx_keystream: three-word combined tausworthe generator state and keystream byte
// depends on tkx_pkg for the step and warm-up functions
`default_nettype none

module tkx_keystream
   import tkx_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire tkx_gen_ctl_type ctl,
   input  wire tkx_words_type   seeds,
   output logic [7:0]           key_byte
);

   tkx_words_type gen_ff, gen_in;
   tkx_words_type stepped;
   tkx_words_type seeded;
   logic [31:0]   mixed;

   always_comb begin
      stepped  = tkx_advance(gen_ff);
      seeded.a = seeds.a | SEED_OR_A;
      seeded.b = seeds.b | SEED_OR_B;
      seeded.c = seeds.c | SEED_OR_C;
      mixed    = stepped.a ^ stepped.b ^ stepped.c;
      key_byte = mixed[7:0];
   end

   always_comb begin
      priority if (ctl.load) begin
         gen_in = tkx_warmup(seeded);
      end else if (ctl.advance) begin
         gen_in = stepped;
      end else begin
         gen_in = gen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0;
      end else begin
         gen_ff <= gen_in;
      end
   end

   a_ctl_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && ctl.advance))
      else $error("generator load and advance together");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!ctl.load && !ctl.advance) |=> $stable(gen_ff))
      else $error("generator state moved without a request");

   a_zero_stays_zero: assert property (@(posedge clock) disable iff (reset)
      (gen_ff == '0 && !ctl.load) |=> gen_ff == '0)
      else $error("all-zero generator left zero without a restart");

endmodule

`default_nettype wire

// File: hw/rtl/tausworthe_keystream_xor.sv
// tausworthe_keystream_xor: byte stream cipher, input register -> generator -> result register
// a data beat goes through the input register, then the result register; restart gives none
// throughput: one beat per cycle while rsp_ready takes results, set by the generator update
// a restart applies the six warm-up steps as it loads, so a data beat may follow at once
// reset (synchronous, active high) clears the seeds, generator words and all valid flags
`default_nettype none

module tausworthe_keystream_xor
   import tkx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   tkx_words_type   seeds_ff;
   tkx_gen_ctl_type gen_ctl;
   logic [1:0]      reg_index;
   logic            csr_write;

   logic            s1_valid_ff, s1_valid_in;
   logic            s1_op_ff;
   logic [7:0]      s1_byte_ff;
   logic            s1_move;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff;
   logic [7:0]      key_byte;

   // configuration port
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (reg_index)
         REG_SEED_A: csr_prdata = seeds_ff.a;
         REG_SEED_B: csr_prdata = seeds_ff.b;
         REG_SEED_C: csr_prdata = seeds_ff.c;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_SEED_A: seeds_ff.a <= csr_pwdata;
            REG_SEED_B: seeds_ff.b <= csr_pwdata;
            REG_SEED_C: seeds_ff.c <= csr_pwdata;
            default:    ;
         endcase
      end
   end

   // restart beats leave the input register without needing the result slot
   assign s1_move = s1_valid_ff &&
                    (s1_op_ff == OP_RESTART || !out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;

   assign gen_ctl.load    = s1_move && s1_op_ff == OP_RESTART;
   assign gen_ctl.advance = s1_move && s1_op_ff == OP_DATA;

   tkx_keystream u_keystream (
      .clock    (clock),
      .reset    (reset),
      .ctl      (gen_ctl),
      .seeds    (seeds_ff),
      .key_byte (key_byte)
   );

   always_comb begin
      s1_valid_in  = (s1_valid_ff && !s1_move) || (req_valid && req_ready);
      out_valid_in = gen_ctl.advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff   <= req_op;
         s1_byte_ff <= req_data_byte;
      end
      if (gen_ctl.advance) begin
         out_byte_ff <= s1_byte_ff ^ key_byte;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input register empty but beat refused");

   a_data_gives_result: assert property (@(posedge clock) disable iff (reset)
      gen_ctl.advance |=> rsp_valid)
      else $error("data beat produced no result");

   a_restart_no_result: assert property (@(posedge clock) disable iff (reset)
      (gen_ctl.load && (!out_valid_ff || rsp_ready)) |=> !rsp_valid)
      else $error("restart beat produced a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !gen_ctl.advance)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking testbench for tausworthe_keystream_xor, directed table then random phases
// depends on tkx_pkg (words type, masks, seed or-values, op and register codes) and the block rtl
`timescale 1ns / 100ps

module tb_top;
   import tkx_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_GAP        = 60;
   localparam int MAX_REPORTS    = 10;
   localparam int NUM_PHASES     = 5;
   localparam int PHASE_BEATS    = 200;
   localparam int PRESSURE_PHASE = 4;

   // index past the last seed register, writes there must change nothing
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_op = OP_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_ready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   wire         req_ready;
   wire         rsp_valid;
   wire  [7:0]  rsp_out_byte;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   tausworthe_keystream_xor u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // keystream model state
   tkx_words_type seed_model = '0;
   tkx_words_type gen_model  = '0;
   logic [7:0]    expected_bytes [$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_req = 1'b0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;

   typedef struct {
      bit          reseed;
      logic [31:0] sa;
      logic [31:0] sb;
      logic [31:0] sc;
      logic        op;
      logic [7:0]  din;
      bit          fixed;
      logic [7:0]  fixed_byte;
   } beat_row_type;

   beat_row_type directed_rows [$];

   function automatic tkx_words_type taus_step(input tkx_words_type w);
      tkx_words_type n;
      logic [31:0]   fb;
      fb  = (w.a << 13) ^ w.a;
      n.a = ((w.a & MASK_A) << 12) ^ (fb >> 19);
      fb  = (w.b << 2) ^ w.b;
      n.b = ((w.b & MASK_B) << 4) ^ (fb >> 25);
      fb  = (w.c << 3) ^ w.c;
      n.c = ((w.c & MASK_C) << 17) ^ (fb >> 11);
      return n;
   endfunction

   // advances the model for one accepted beat, returns 1 when a result beat follows
   function automatic bit keystream_apply(input logic op, input logic [7:0] din,
                                          output logic [7:0] dout);
      tkx_words_type w;
      logic [31:0]   ks;
      dout = 8'h00;
      if (op == OP_RESTART) begin
         w.a = seed_model.a | SEED_OR_A;
         w.b = seed_model.b | SEED_OR_B;
         w.c = seed_model.c | SEED_OR_C;
         for (int k = 0; k < WARMUP_STEPS; k++) w = taus_step(w);
         gen_model = w;
         return 1'b0;
      end
      gen_model = taus_step(gen_model);
      ks = gen_model.a ^ gen_model.b ^ gen_model.c;
      dout = din ^ ks[7:0];
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic add_row(input bit reseed, input logic [31:0] sa, input logic [31:0] sb,
                          input logic [31:0] sc, input logic op, input logic [7:0] din,
                          input bit fixed, input logic [7:0] fixed_byte);
      beat_row_type r;
      r.reseed = reseed;
      r.sa = sa;
      r.sb = sb;
      r.sc = sc;
      r.op = op;
      r.din = din;
      r.fixed = fixed;
      r.fixed_byte = fixed_byte;
      directed_rows.push_back(r);
   endtask

   // called at a rising edge; leaves psel high so writes can follow back to back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SEED_A: seed_model.a = value;
         REG_SEED_B: seed_model.b = value;
         REG_SEED_C: seed_model.c = value;
         default: ;
      endcase
   endtask

   // wait until every result is back and the pipeline has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_seeds(input logic [31:0] sa, input logic [31:0] sb,
                             input logic [31:0] sc);
      settle();
      csr_write(REG_SEED_A, sa);
      csr_write(REG_SEED_B, sb);
      csr_write(REG_SEED_C, sc);
      csr_write(REG_UNUSED, $urandom());
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_beat(input logic op, input logic [7:0] din,
                            input bit fixed, input logic [7:0] fixed_byte);
      logic [7:0] predicted;
      bit         produces;
      int         gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= din;
      do @(posedge clock); while (!req_ready);
      produces = keystream_apply(op, din, predicted);
      if (produces) expected_bytes.push_back(fixed ? fixed_byte : predicted);
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] exp_byte,
                                  input logic [7:0] got_byte);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_byte, got_byte);
   endtask

   // result side: compare every accepted beat with the oldest pending byte
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("result beat with nothing pending", 8'h00, rsp_out_byte);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want) report_mismatch("out_byte", want, rsp_out_byte);
         end
      end
   end

   // receiver back-pressure, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      beat_row_type r;
      logic         op;
      // before any restart the generator is all zero, so bytes pass straight through
      add_row(0, 0, 0, 0, OP_DATA,    8'h00, 1, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'hFF, 1, 8'hFF);
      add_row(0, 0, 0, 0, OP_DATA,    8'h5A, 1, 8'h5A);
      add_row(0, 0, 0, 0, OP_DATA,    8'hA5, 1, 8'hA5);
      // restart from reset seeds, only the forced low bits are set
      add_row(0, 0, 0, 0, OP_RESTART, 8'hFF, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'h00, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'hFF, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'h01, 0, 8'h00);
      // new seeds do nothing until the next restart
      add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_DATA, 8'h80, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'h7F, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_RESTART, 8'h00, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'h00, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'hFF, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_RESTART, 8'h12, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_RESTART, 8'h34, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'h55, 0, 8'h00);
      add_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, OP_RESTART, 8'h00, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'hAA, 0, 8'h00);
      add_row(1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, OP_RESTART, 8'h00, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'h00, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'hFF, 0, 8'h00);
      add_row(1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678, OP_RESTART, 8'hFF, 0, 8'h00);
      add_row(0, 0, 0, 0, OP_DATA,    8'hC3, 0, 8'h00);

      while (reset) @(posedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.reseed) load_seeds(r.sa, r.sb, r.sc);
         send_beat(r.op, r.din, r.fixed, r.fixed_byte);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         load_seeds(pick_seed(), pick_seed(), pick_seed());
         case (p)
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            3: begin send_idle_pct = 15; rsp_stall_pct = 15; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         // sender keeps offering while the receiver holds off, filling the block
         if (p == PRESSURE_PHASE) hold_req = 1'b1;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            op = (n == 0 || $urandom_range(9) == 0) ? OP_RESTART : OP_DATA;
            send_beat(op, 8'($urandom_range(255)), 1'b0, 8'h00);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: tausworthe_keystream_xor.f
hw/rtl/tkx_pkg.sv
hw/rtl/tkx_keystream.sv
hw/rtl/tausworthe_keystream_xor.sv
tb/tb_top.sv
